// ----- rtl/u2u8_pkg.sv -----
// Shared types, constants and byte-forming function for the UCS-2 to UTF-8 encoder.
package u2u8_pkg;

	localparam int unsigned UNIT_W   = 16;
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned CNT_W    = 16;
	localparam int unsigned QDEPTH   = 2;
	localparam int unsigned QPTR_W   = $clog2(QDEPTH);
	localparam int unsigned QCNT_W   = $clog2(QDEPTH + 1);

	localparam logic [UNIT_W-1:0] ONE_BYTE_MAX = 16'h007F;
	localparam logic [UNIT_W-1:0] TWO_BYTE_MAX = 16'h07FF;
	localparam logic [CNT_W-1:0]  CAP_RESET    = 16'd256;

	localparam logic [1:0] SZ_ONE   = 2'd1;
	localparam logic [1:0] SZ_TWO   = 2'd2;
	localparam logic [1:0] SZ_THREE = 2'd3;

	localparam logic [2:0] LEAD2 = 3'b110;
	localparam logic [3:0] LEAD3 = 4'b1110;
	localparam logic [1:0] CONT  = 2'b10;

	typedef logic [1:0] size_t;

	typedef struct packed {
		logic              term;
		size_t             size;
		logic [UNIT_W-1:0] code;
		logic [CNT_W-1:0]  bytes_total;
		logic [CNT_W-1:0]  chars_total;
	} entry_t;

	function automatic logic [BYTE_W-1:0] utf8_byte(input logic [UNIT_W-1:0] code,
	                                                 input size_t size, input logic [1:0] idx);
		logic [BYTE_W-1:0] b;
		b = '0;
		case (size)
			SZ_ONE: b = code[7:0];
			SZ_TWO: b = (idx == 2'd0) ? {LEAD2, code[10:6]} : {CONT, code[5:0]};
			SZ_THREE: begin
				case (idx)
					2'd0:    b = {LEAD3, code[15:12]};
					2'd1:    b = {CONT, code[11:6]};
					default: b = {CONT, code[5:0]};
				endcase
			end
			default: b = '0;
		endcase
		return b;
	endfunction

endpackage

// ----- rtl/u2u8_front.sv -----
// Front end: takes code units, holds capacity and string state, classifies and queues work.
module u2u8_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [u2u8_pkg::CNT_W-1:0]    cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [u2u8_pkg::UNIT_W-1:0]   code_unit,
	input  logic                          q_full,
	output logic                          push,
	output u2u8_pkg::entry_t              push_data
);
	import u2u8_pkg::*;

	logic [CNT_W-1:0] capacity_q;
	logic [CNT_W-1:0] wpos_q;
	logic [CNT_W-1:0] chars_q;
	logic             stopped_q;

	logic             accept;
	logic             is_zero;
	size_t            size;
	logic [CNT_W:0]   next_pos;
	logic             fits;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign is_zero  = (code_unit == '0);

	always_comb begin
		if (code_unit <= ONE_BYTE_MAX)
			size = SZ_ONE;
		else if (code_unit <= TWO_BYTE_MAX)
			size = SZ_TWO;
		else
			size = SZ_THREE;
	end

	assign next_pos = {1'b0, wpos_q} + {{(CNT_W - 1){1'b0}}, size};
	assign fits     = next_pos < {1'b0, capacity_q};
	assign push     = accept && (is_zero || (!stopped_q && fits));

	always_comb begin
		push_data.term        = is_zero;
		push_data.size        = is_zero ? SZ_ONE : size;
		push_data.code        = code_unit;
		push_data.bytes_total = is_zero ? wpos_q : '0;
		push_data.chars_total = is_zero ? chars_q : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_we) begin
			capacity_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wpos_q    <= '0;
			chars_q   <= '0;
			stopped_q <= 1'b0;
		end else if (accept) begin
			if (is_zero) begin
				wpos_q    <= '0;
				chars_q   <= '0;
				stopped_q <= 1'b0;
			end else if (!stopped_q) begin
				if (fits) begin
					wpos_q  <= next_pos[CNT_W-1:0];
					chars_q <= chars_q + CNT_W'(1);
				end else begin
					stopped_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ----- rtl/u2u8_fifo.sv -----
// Short queue of classified units between front and back end.
module u2u8_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  u2u8_pkg::entry_t push_data,
	input  logic             pop,
	output logic             full,
	output logic             head_valid,
	output u2u8_pkg::entry_t head
);
	import u2u8_pkg::*;

	entry_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wptr_q;
	logic [QPTR_W-1:0]   rptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign full       = (count_q == QCNT_W'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wptr_q <= wptr_q + QPTR_W'(1);
			if (pop)
				rptr_q <= rptr_q + QPTR_W'(1);
			if (push && !pop)
				count_q <= count_q + QCNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - QCNT_W'(1);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) pop |-> head_valid)
		else $error("queue read while empty");

endmodule

// ----- rtl/u2u8_back.sv -----
// Back end: splits each queued unit into UTF-8 bytes, one per cycle while out_stall is low, into the output register.
module u2u8_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         head_valid,
	input  u2u8_pkg::entry_t             head,
	output logic                         pop,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [u2u8_pkg::BYTE_W-1:0]  out_byte,
	output logic                         last_byte,
	output logic                         is_terminator,
	output logic [u2u8_pkg::CNT_W-1:0]   bytes_total,
	output logic [u2u8_pkg::CNT_W-1:0]   chars_total
);
	import u2u8_pkg::*;

	logic [1:0]        idx_q;
	logic              out_valid_q;
	logic [BYTE_W-1:0] byte_q;
	logic              last_q;
	logic              term_q;
	logic [CNT_W-1:0]  btot_q;
	logic [CNT_W-1:0]  ctot_q;

	logic              load;
	logic              is_last;

	assign load    = head_valid && (!out_valid_q || !out_stall);
	assign is_last = (idx_q == head.size - 2'd1);
	assign pop     = load && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= is_last ? 2'd0 : idx_q + 2'd1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= utf8_byte(head.code, head.size, idx_q);
			last_q <= is_last;
			term_q <= head.term;
			btot_q <= head.bytes_total;
			ctot_q <= head.chars_total;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_byte      = byte_q;
	assign last_byte     = last_q;
	assign is_terminator = term_q;
	assign bytes_total   = btot_q;
	assign chars_total   = ctot_q;

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> (idx_q < head.size))
		else $error("byte index beyond unit size");
	a_term_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && term_q |-> last_q)
		else $error("terminator not marked as final byte");

endmodule

// ----- rtl/ucs2_to_utf8_encoder.sv -----
// Top level of the UCS-2 to UTF-8 encoder: front end, queue and byte serialiser.
// Path: an accepted unit is written into the queue, and its first byte is then loaded
// into the output register.
// Throughput: one output byte per cycle while out_stall is low; a unit gives 1 to 3 bytes.
// Input is taken every cycle while the two-entry queue has room.
// Reset (arst_n low): queue and output empty, totals and stop flag cleared, capacity 256.
module ucs2_to_utf8_encoder (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [u2u8_pkg::CNT_W-1:0]   cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [u2u8_pkg::UNIT_W-1:0]  code_unit,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [u2u8_pkg::BYTE_W-1:0]  out_byte,
	output logic                         last_byte,
	output logic                         is_terminator,
	output logic [u2u8_pkg::CNT_W-1:0]   bytes_total,
	output logic [u2u8_pkg::CNT_W-1:0]   chars_total
);
	import u2u8_pkg::*;

	logic   push;
	entry_t push_data;
	logic   q_full;
	logic   pop;
	logic   head_valid;
	entry_t head;

	u2u8_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.code_unit (code_unit),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	u2u8_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head)
	);

	u2u8_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head          (head),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_byte      (out_byte),
		.last_byte     (last_byte),
		.is_terminator (is_terminator),
		.bytes_total   (bytes_total),
		.chars_total   (chars_total)
	);

endmodule

// ----- tb/sv/ucs2_to_utf8_encoder_test.sv -----
// Self-checking testbench for the UCS-2 to UTF-8 encoder: directed and random strings.
module ucs2_to_utf8_encoder_test;
	timeunit 1ns;
	timeprecision 1ps;

	import u2u8_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASE_UNITS = 60;
	localparam logic [UNIT_W-1:0] END_OF_STRING = 16'h0000;
	localparam logic [UNIT_W-1:0] BOUNDARY_UNITS [9] = '{16'h0041, 16'h0001, 16'h007F,
		16'h0080, 16'h07FF, 16'h0800, 16'hFFFF, 16'hD83D, 16'hDE00};

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
		logic              term;
		logic [CNT_W-1:0]  nbytes;
		logic [CNT_W-1:0]  nchars;
	} utf8_out_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [CNT_W-1:0]    cfg_wdata = '0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [UNIT_W-1:0]   code_unit = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [BYTE_W-1:0]   out_byte;
	logic                last_byte;
	logic                is_terminator;
	logic [CNT_W-1:0]    bytes_total;
	logic [CNT_W-1:0]    chars_total;

	logic [UNIT_W-1:0]   pending_units[$];
	utf8_out_t           expected_bytes[$];

	// encoder state as predicted
	logic [CNT_W-1:0]    capacity_model = CAP_RESET;
	logic [CNT_W-1:0]    position_model = '0;
	logic [CNT_W-1:0]    chars_model = '0;
	logic                halted_model = 1'b0;

	int                  units_queued = 0;
	int                  units_taken = 0;
	int                  mismatches = 0;
	int                  cycle_count = 0;
	int                  hold_left = 0;
	logic                hold_req = 1'b0;
	logic                sender_idle = 1'b0;
	logic                receiver_stall = 1'b0;

	ucs2_to_utf8_encoder uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.code_unit(code_unit),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte(out_byte),
		.last_byte(last_byte),
		.is_terminator(is_terminator),
		.bytes_total(bytes_total),
		.chars_total(chars_total)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	task automatic encode_unit(input logic [UNIT_W-1:0] u);
		int unsigned need;
		logic [BYTE_W-1:0] seq[3];
		utf8_out_t item;
		if (u == END_OF_STRING) begin
			item = '{8'h00, 1'b1, 1'b1, position_model, chars_model};
			expected_bytes = {expected_bytes, item};
			position_model = '0;
			chars_model = '0;
			halted_model = 1'b0;
		end else if (!halted_model) begin
			if (u <= ONE_BYTE_MAX)
				need = 1;
			else if (u <= TWO_BYTE_MAX)
				need = 2;
			else
				need = 3;
			if (32'(position_model) + need >= 32'(capacity_model)) begin
				halted_model = 1'b1;
			end else begin
				case (need)
					1: seq[0] = u[7:0];
					2: begin
						seq[0] = {3'b110, u[10:6]};
						seq[1] = {2'b10, u[5:0]};
					end
					default: begin
						seq[0] = {4'b1110, u[15:12]};
						seq[1] = {2'b10, u[11:6]};
						seq[2] = {2'b10, u[5:0]};
					end
				endcase
				for (int i = 0; i < need; i++) begin
					item = '{seq[i], 1'(i == need - 1), 1'b0, 16'h0, 16'h0};
					expected_bytes = {expected_bytes, item};
				end
				position_model = position_model + 16'(need);
				chars_model = chars_model + 16'd1;
			end
		end
	endtask

	// driver: presents pending units, predicts on each accepted transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				encode_unit(code_unit);
				units_taken++;
			end
			if (cfg_we)
				capacity_model = cfg_wdata;
			if (!in_valid || !in_stall) begin
				if (pending_units.size() != 0 &&
					!(sender_idle && $urandom_range(99) < (receiver_stall ? 37 : 86))) begin
					in_valid <= 1'b1;
					code_unit <= pending_units.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks each output transaction against the oldest prediction
	always @(posedge clk) begin : monitor
		utf8_out_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_bytes.size() == 0) begin
					$error("unexpected out_byte %h", out_byte);
					mismatches++;
				end else begin
					want = expected_bytes.pop_front();
					if (out_byte !== want.data) begin
						$error("out_byte: expected %h, got %h", want.data, out_byte);
						mismatches++;
					end
					if (last_byte !== want.last) begin
						$error("last_byte: expected %b, got %b", want.last, last_byte);
						mismatches++;
					end
					if (is_terminator !== want.term) begin
						$error("is_terminator: expected %b, got %b", want.term, is_terminator);
						mismatches++;
					end
					if (bytes_total !== want.nbytes) begin
						$error("bytes_total: expected %0d, got %0d", want.nbytes, bytes_total);
						mismatches++;
					end
					if (chars_total !== want.nchars) begin
						$error("chars_total: expected %0d, got %0d", want.nchars, chars_total);
						mismatches++;
					end
				end
			end
			out_stall <= (hold_left != 0) ||
				(receiver_stall && $urandom_range(99) < (sender_idle ? 37 : 86));
		end
	end

	// long receiver hold-off to back the block up
	always @(posedge clk) begin
		if (hold_req)
			hold_left <= HOLD_CYCLES;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("ucs2_to_utf8_encoder test failed");
			$finish;
		end
	end

	task automatic queue_unit(input logic [UNIT_W-1:0] u);
		pending_units = {pending_units, u};
		units_queued++;
	endtask

	task automatic write_capacity(input logic [CNT_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic settle();
		while (units_taken != units_queued || expected_bytes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [UNIT_W-1:0] pick_code_unit();
		logic [UNIT_W-1:0] edges[6];
		edges = '{16'h0001, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hFFFF};
		case ($urandom_range(4))
			0: return 16'($urandom_range(16'h007F, 16'h0001));
			1: return 16'($urandom_range(16'h07FF, 16'h0080));
			2: return 16'($urandom_range(16'hFFFF, 16'h0800));
			3: return 16'($urandom_range(16'hDFFF, 16'hD800));
			default: return edges[$urandom_range(5)];
		endcase
	endfunction

	task automatic run_phase(input logic idle_in, input logic stall_out,
		input logic [CNT_W-1:0] cap, input int max_len, input logic squeeze);
		int start;
		int len;
		sender_idle <= idle_in;
		receiver_stall <= stall_out;
		write_capacity(cap);
		if (squeeze) begin
			hold_req <= 1'b1;
			@(posedge clk);
			hold_req <= 1'b0;
		end
		start = units_queued;
		while (units_queued - start < PHASE_UNITS) begin
			len = $urandom_range(max_len);
			repeat (len) queue_unit(pick_code_unit());
			// now and then leave a string open so the next one runs on
			if ($urandom_range(7) != 0)
				queue_unit(END_OF_STRING);
			while (pending_units.size() >= 4)
				@(posedge clk);
		end
		settle();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		write_capacity(16'd20);
		// empty string, every size boundary, a surrogate pair, then exact overflow and a later unit that fits but is dropped
		queue_unit(END_OF_STRING);
		for (int i = 0; i < 9; i++)
			queue_unit(BOUNDARY_UNITS[i]);
		queue_unit(END_OF_STRING);
		repeat (6) queue_unit(16'hFFFF);
		queue_unit(16'h0080);
		queue_unit(16'h0041);
		queue_unit(END_OF_STRING);
		settle();

		run_phase(1'b0, 1'b0, 16'($urandom_range(40, 8)), 12, 1'b1);
		run_phase(1'b1, 1'b0, 16'hFFFF, 12, 1'b0);
		run_phase(1'b0, 1'b1, 16'd1, 3, 1'b0);
		run_phase(1'b1, 1'b1, 16'($urandom_range(12, 2)), 8, 1'b0);
		run_phase(1'b0, 1'b0, 16'($urandom_range(64, 16)), 12, 1'b0);
		run_phase(1'b1, 1'b1, 16'($urandom_range(30, 3)), 10, 1'b0);

		if (mismatches == 0)
			$display("ucs2_to_utf8_encoder test passed");
		else
			$display("ucs2_to_utf8_encoder test failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/u2u8_pkg.sv
rtl/u2u8_front.sv
rtl/u2u8_fifo.sv
rtl/u2u8_back.sv
rtl/ucs2_to_utf8_encoder.sv
tb/sv/ucs2_to_utf8_encoder_test.sv
